/* src/flpt_pkg.sv */
package flpt_pkg;

	localparam int LEVELS_DEF  = 4;
	localparam int INDEX_BITS  = 9;
	localparam int PAGE_SHIFT  = 12;
	localparam int VA_W        = 48;
	localparam int PA_W        = 52;
	localparam int ENTRY_W     = 64;
	localparam int ROOT_W      = 40;
	localparam int CFG_IDX_W   = 2;
	localparam int QUEUE_DEPTH = 2;

	localparam int BIT_PRESENT = 0;
	localparam int BIT_USER    = 2;
	localparam int BIT_LARGE   = 7;

	localparam logic MODE_REQ  = 1'b0;
	localparam logic MODE_RESP = 1'b1;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	localparam logic [1:0] STATUS_FOUND       = 2'd0;
	localparam logic [1:0] STATUS_NOT_PRESENT = 2'd1;
	localparam logic [1:0] STATUS_NO_USER     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ROOT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK = 2'd1;

	typedef struct packed {
		logic               mode;
		logic [VA_W-1:0]    vaddr;
		logic [ENTRY_W-1:0] entry;
		logic               present;
		logic               page_size;
		logic               user;
	} walk_item_t;

endpackage

/* src/flpt_front.sv */
module flpt_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           mode,
	input  logic [flpt_pkg::VA_W-1:0]      virt_addr,
	input  logic [flpt_pkg::ENTRY_W-1:0]   read_data,
	output logic                           push,
	input  logic                           push_ready,
	output flpt_pkg::walk_item_t           push_item
);

	logic                 valid_s1;
	flpt_pkg::walk_item_t item_s1;
	flpt_pkg::walk_item_t item_d;
	logic                 load;

	always_comb begin
		item_d.mode      = mode;
		item_d.vaddr     = virt_addr;
		item_d.entry     = read_data;
		item_d.present   = read_data[flpt_pkg::BIT_PRESENT];
		item_d.page_size = read_data[flpt_pkg::BIT_LARGE];
		item_d.user      = read_data[flpt_pkg::BIT_USER];
	end

	assign in_stall  = valid_s1 && !push_ready;
	assign load      = in_valid && !in_stall;
	assign push      = valid_s1;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_d;
		end
	end

endmodule

/* src/flpt_fifo.sv */
module flpt_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 push_ready,
	input  flpt_pkg::walk_item_t push_item,
	output logic                 head_valid,
	input  logic                 pop,
	output flpt_pkg::walk_item_t head_item
);

	localparam int PTR_W = $clog2(flpt_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(flpt_pkg::QUEUE_DEPTH + 1);

	flpt_pkg::walk_item_t mem_q [flpt_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q < CNT_W'(flpt_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_item  = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(flpt_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* src/flpt_back.sv */
module flpt_back #(
	parameter int LEVELS = flpt_pkg::LEVELS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             head_valid,
	input  flpt_pkg::walk_item_t             head_item,
	output logic                             pop,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [flpt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [flpt_pkg::ENTRY_W-1:0]     cfg_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             kind,
	output logic [flpt_pkg::PA_W-1:0]        read_addr,
	output logic [1:0]                       status,
	output logic [1:0]                       leaf_level,
	output logic [flpt_pkg::ENTRY_W-1:0]     leaf_entry,
	output logic [flpt_pkg::PA_W-1:0]        frame_base
);

	localparam int LVL_W = $clog2(LEVELS);

	logic                              busy_q;
	logic [LVL_W-1:0]                  lvl_q;
	logic [flpt_pkg::VA_W-1:0]         held_q;
	logic [flpt_pkg::ROOT_W-1:0]       root_q;
	logic                              check_q;

	logic                              out_valid_q;
	logic                              kind_q;
	logic [flpt_pkg::PA_W-1:0]         read_addr_q;
	logic [1:0]                        status_q;
	logic [1:0]                        leaf_level_q;
	logic [flpt_pkg::ENTRY_W-1:0]      leaf_entry_q;
	logic [flpt_pkg::PA_W-1:0]         frame_base_q;

	logic                              is_req;
	logic                              ignore;
	logic                              last;
	logic                              finish;
	logic [LVL_W-1:0]                  next_lvl;
	logic [flpt_pkg::VA_W-1:0]         off_va;
	logic [5:0]                        shift_amt;
	logic [flpt_pkg::INDEX_BITS-1:0]   idx;
	logic [flpt_pkg::PA_W-1:0]         base;
	logic [flpt_pkg::PA_W-1:0]         addr;
	logic [flpt_pkg::PA_W-1:0]         frame;
	logic [1:0]                        done_status;

	assign cfg_ready = 1'b1;
	assign pop       = head_valid && (!out_valid_q || !out_stall);

	always_comb begin
		int sh;
		is_req   = head_item.mode == flpt_pkg::MODE_REQ;
		ignore   = is_req ? busy_q : !busy_q;
		last     = lvl_q == LVL_W'(LEVELS - 1);
		finish   = !is_req && (!head_item.present || last || head_item.page_size);
		next_lvl = is_req ? '0 : lvl_q + 1'b1;
		off_va   = is_req ? head_item.vaddr : held_q;
		sh       = flpt_pkg::PAGE_SHIFT
		         + (LEVELS - 1 - int'(next_lvl)) * flpt_pkg::INDEX_BITS;
		shift_amt = 6'(sh);
		idx      = flpt_pkg::INDEX_BITS'(off_va >> shift_amt);
		frame    = {head_item.entry[flpt_pkg::PA_W-1:flpt_pkg::PAGE_SHIFT],
		            flpt_pkg::PAGE_SHIFT'(0)};
		base     = is_req ? {root_q, flpt_pkg::PAGE_SHIFT'(0)} : frame;
		addr     = base + flpt_pkg::PA_W'({idx, 3'b000});
		if (!head_item.present) begin
			done_status = flpt_pkg::STATUS_NOT_PRESENT;
		end else if (check_q && !head_item.user) begin
			done_status = flpt_pkg::STATUS_NO_USER;
		end else begin
			done_status = flpt_pkg::STATUS_FOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			lvl_q       <= '0;
			held_q      <= '0;
			root_q      <= '0;
			check_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					flpt_pkg::CFG_ROOT:  root_q  <= cfg_data[flpt_pkg::ROOT_W-1:0];
					flpt_pkg::CFG_CHECK: check_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (pop) begin
				out_valid_q <= !ignore;
				if (!ignore) begin
					if (is_req) begin
						busy_q <= 1'b1;
						lvl_q  <= '0;
						held_q <= head_item.vaddr;
					end else if (finish) begin
						busy_q <= 1'b0;
						lvl_q  <= '0;
					end else begin
						lvl_q <= next_lvl;
					end
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !ignore) begin
			if (finish) begin
				kind_q       <= flpt_pkg::KIND_DONE;
				read_addr_q  <= '0;
				status_q     <= done_status;
				leaf_level_q <= 2'(lvl_q);
				leaf_entry_q <= head_item.entry;
				frame_base_q <= head_item.present ? frame : '0;
			end else begin
				kind_q       <= flpt_pkg::KIND_READ;
				read_addr_q  <= addr;
				status_q     <= flpt_pkg::STATUS_FOUND;
				leaf_level_q <= '0;
				leaf_entry_q <= '0;
				frame_base_q <= '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign read_addr  = read_addr_q;
	assign status     = status_q;
	assign leaf_level = leaf_level_q;
	assign leaf_entry = leaf_entry_q;
	assign frame_base = frame_base_q;

endmodule

/* src/four_level_page_table_walker_unit.sv */
// Results pass the input stage, queue and output register; walk decision and address add are
// combinational. Throughput: one request per cycle unless in_stall or out_stall holds it.
// Walk time is set by the external memory returning each table entry as a response request.
// Reset (arst_n low, asynchronous): walker idle, level zero, config registers zero, queue empty.
// Configuration writes are taken every cycle; write them only while the walker is idle.
module four_level_page_table_walker_unit #(
	parameter int LEVELS = flpt_pkg::LEVELS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             mode,
	input  logic [flpt_pkg::VA_W-1:0]        virt_addr,
	input  logic [flpt_pkg::ENTRY_W-1:0]     read_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             kind,
	output logic [flpt_pkg::PA_W-1:0]        read_addr,
	output logic [1:0]                       status,
	output logic [1:0]                       leaf_level,
	output logic [flpt_pkg::ENTRY_W-1:0]     leaf_entry,
	output logic [flpt_pkg::PA_W-1:0]        frame_base,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [flpt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [flpt_pkg::ENTRY_W-1:0]     cfg_data
);

	logic                 push;
	logic                 push_ready;
	flpt_pkg::walk_item_t push_item;
	logic                 head_valid;
	logic                 pop;
	flpt_pkg::walk_item_t head_item;

	flpt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.virt_addr  (virt_addr),
		.read_data  (read_data),
		.push       (push),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	flpt_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_item  (push_item),
		.head_valid (head_valid),
		.pop        (pop),
		.head_item  (head_item)
	);

	flpt_back #(
		.LEVELS (LEVELS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.read_addr  (read_addr),
		.status     (status),
		.leaf_level (leaf_level),
		.leaf_entry (leaf_entry),
		.frame_base (frame_base)
	);

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import flpt_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam int WALK_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 235;
	localparam int PRINT_CAP = 40;

	typedef struct packed {
		logic               kind;
		logic [PA_W-1:0]    read_addr;
		logic [1:0]         status;
		logic [1:0]         leaf_level;
		logic [ENTRY_W-1:0] leaf_entry;
		logic [PA_W-1:0]    frame_base;
	} walk_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 mode = MODE_REQ;
	logic [VA_W-1:0]      virt_addr = '0;
	logic [ENTRY_W-1:0]   read_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 kind;
	logic [PA_W-1:0]      read_addr;
	logic [1:0]           status;
	logic [1:0]           leaf_level;
	logic [ENTRY_W-1:0]   leaf_entry;
	logic [PA_W-1:0]      frame_base;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ENTRY_W-1:0]   cfg_data = '0;

	walk_result_t pending_results[$];

	logic [ROOT_W-1:0] walk_root = '0;
	logic              check_user_bit = 1'b0;
	logic              walk_busy = 1'b0;
	int                walk_level = 0;
	logic [VA_W-1:0]   walk_vaddr = '0;

	int  err_count = 0;
	int  n_effective = 0;
	int  n_ignored = 0;
	int  n_reads = 0;
	int  n_found = 0;
	int  n_absent = 0;
	int  n_user_fault = 0;
	int  n_reg_writes = 0;
	int  n_out_stalls = 0;
	int  stall_left = 0;
	bit  tx_quiet = 1'b0;
	bit  rx_quiet = 1'b0;

	four_level_page_table_walker_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.virt_addr  (virt_addr),
		.read_data  (read_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.read_addr  (read_addr),
		.status     (status),
		.leaf_level (leaf_level),
		.leaf_entry (leaf_entry),
		.frame_base (frame_base),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [PA_W-1:0] index_offset(int lvl);
		int sh;
		logic [63:0] idx;
		logic [PA_W-1:0] off;
		sh = PAGE_SHIFT + (LEVELS_DEF - 1 - lvl) * INDEX_BITS;
		idx = '0;
		if (sh < 64)
			idx = ({16'b0, walk_vaddr} >> sh) & ((64'd1 << INDEX_BITS) - 64'd1);
		off = PA_W'(idx * 64'd8);
		return off;
	endfunction

	task automatic predict_walk_step(input logic m, input logic [VA_W-1:0] va,
		input logic [ENTRY_W-1:0] d);
		walk_result_t r;
		logic [PA_W-1:0] table_base;
		r = '0;
		table_base = {d[PA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
		if (m == MODE_REQ) begin
			if (walk_busy) begin
				n_ignored++;
				return;
			end
			walk_vaddr = va;
			walk_level = 0;
			walk_busy = 1'b1;
			r.kind = KIND_READ;
			r.read_addr = {walk_root, {PAGE_SHIFT{1'b0}}} + index_offset(0);
			n_reads++;
		end else begin
			if (!walk_busy) begin
				n_ignored++;
				return;
			end
			r.leaf_entry = d;
			r.leaf_level = walk_level[1:0];
			if (!d[BIT_PRESENT]) begin
				walk_busy = 1'b0;
				walk_level = 0;
				r.kind = KIND_DONE;
				r.status = STATUS_NOT_PRESENT;
				n_absent++;
			end else if (walk_level + 1 >= LEVELS_DEF || d[BIT_LARGE]) begin
				walk_busy = 1'b0;
				walk_level = 0;
				r.kind = KIND_DONE;
				r.frame_base = table_base;
				if (check_user_bit && !d[BIT_USER]) begin
					r.status = STATUS_NO_USER;
					n_user_fault++;
				end else begin
					r.status = STATUS_FOUND;
					n_found++;
				end
			end else begin
				walk_level++;
				r = '0;
				r.kind = KIND_READ;
				r.read_addr = table_base + index_offset(walk_level);
				n_reads++;
			end
		end
		n_effective++;
		pending_results.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		err_count++;
		if (err_count <= PRINT_CAP)
			$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
	endtask

	task automatic check_result();
		walk_result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("unexpected result, read_addr", 64'(read_addr), '0);
			return;
		end
		want = pending_results.pop_front();
		if (kind !== want.kind)
			report_mismatch("kind", 64'(kind), 64'(want.kind));
		if (read_addr !== want.read_addr)
			report_mismatch("read_addr", 64'(read_addr), 64'(want.read_addr));
		if (status !== want.status)
			report_mismatch("status", 64'(status), 64'(want.status));
		if (leaf_level !== want.leaf_level)
			report_mismatch("leaf_level", 64'(leaf_level), 64'(want.leaf_level));
		if (leaf_entry !== want.leaf_entry)
			report_mismatch("leaf_entry", leaf_entry, want.leaf_entry);
		if (frame_base !== want.frame_base)
			report_mismatch("frame_base", 64'(frame_base), 64'(want.frame_base));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_result();
		if (stall_left == 0 && !rx_quiet)
			stall_left = pick_gap();
		out_stall <= (stall_left != 0);
		if (stall_left != 0) begin
			stall_left--;
			n_out_stalls++;
		end
	end

	task automatic send_item(input logic m, input logic [VA_W-1:0] va,
		input logic [ENTRY_W-1:0] d);
		int gap;
		gap = tx_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		virt_addr <= va;
		read_data <= d;
		do @(posedge clk); while (in_stall);
		predict_walk_step(m, va, d);
	endtask

	task automatic send_request(input logic [VA_W-1:0] va);
		send_item(MODE_REQ, va, rand64());
	endtask

	task automatic send_response(input logic [ENTRY_W-1:0] d);
		logic [63:0] junk;
		junk = rand64();
		send_item(MODE_RESP, junk[VA_W-1:0], d);
	endtask

	task automatic drain_pending();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		drain_pending();
		repeat (6) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_ROOT)
			walk_root = val[ROOT_W-1:0];
		else if (idx == CFG_CHECK)
			check_user_bit = val[0];
		n_reg_writes++;
	endtask

	task automatic test_reset_values();
		send_request('0);
		send_response('0);
		send_response(64'h0000_0000_0000_0001);
	endtask

	task automatic test_full_depth_walk();
		write_register(CFG_ROOT, '1);
		write_register(CFG_CHECK, 64'hFFFF_FFFF_FFFF_FFFE);
		send_request('1);
		send_response(64'hFFFF_FFFF_FFFF_FF7F);
		send_request('0);
		send_response(64'hFFFA_BCDE_F012_3F7F);
		send_response(64'h000F_FFFF_FFFF_F001);
		send_response(64'hFFFF_FFFF_FFFF_FF83);
	endtask

	task automatic test_large_pages();
		write_register(CFG_ROOT, 64'h0000_00AB_CDEF_0123);
		send_request(48'h8040_2010_0000);
		send_response(64'h0000_0000_1234_5081);
		send_request(48'h0123_4567_89AB);
		send_response(64'h0000_0000_0000_1003);
		send_response(64'h0000_00FF_FFE0_00E7);
	endtask

	task automatic test_user_check();
		write_register(CFG_CHECK, 64'h0000_0000_0000_0001);
		send_request(48'h7FFF_0000_FFFF);
		send_response(64'h8000_0000_0040_0081);
		send_request(48'hA5A5_5A5A_A5A5);
		send_response(64'h0000_0000_0000_2001);
		send_response(64'h0000_0000_0000_3001);
		send_response(64'h0000_0000_0000_4001);
		send_response(64'h0000_0000_0000_5007);
		send_request(48'h0000_0000_1000);
		send_response(64'hFFFF_FFFF_FFFF_FFFE);
		write_register(CFG_SPARE_A, '1);
		write_register(CFG_SPARE_B, '0);
		send_request(48'h0000_0000_0008);
		send_response(64'h0000_0000_0000_0081);
	endtask

	task automatic test_random_walks();
		logic [63:0] root_val;
		logic [63:0] chk_val;
		logic [63:0] va;
		logic [63:0] e;
		int goal;
		int walks;
		int r;
		for (int ph = 0; ph < WALK_PHASES; ph++) begin
			root_val = (ph == 0) ? 64'd0 : (ph == 1) ? '1 : rand64();
			chk_val = rand64();
			chk_val[0] = ph[0];
			write_register(CFG_ROOT, root_val);
			write_register(CFG_CHECK, chk_val);
			goal = n_effective + ITEMS_PER_PHASE;
			walks = 0;
			while (n_effective < goal) begin
				if ($urandom_range(0, 19) == 0)
					tx_quiet = !tx_quiet;
				if ($urandom_range(0, 19) == 0)
					rx_quiet = !rx_quiet;
				if (walks == 12)
					drain_pending();
				if ($urandom_range(0, 99) < 4) begin
					e = rand64();
					e[BIT_PRESENT] = 1'($urandom_range(0, 1));
					send_response(e);
				end
				r = $urandom_range(0, 99);
				va = (r < 5) ? '1 : (r < 10) ? '0 : rand64();
				send_request(va[VA_W-1:0]);
				while (walk_busy) begin
					if ($urandom_range(0, 99) < 4) begin
						va = rand64();
						send_request(va[VA_W-1:0]);
					end
					e = rand64();
					e[BIT_PRESENT] = ($urandom_range(0, 99) < 85);
					e[BIT_LARGE] = ($urandom_range(0, 99) < 15);
					e[BIT_USER] = ($urandom_range(0, 99) < 65);
					send_response(e);
				end
				walks++;
			end
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_full_depth_walk();
		test_large_pages();
		test_user_check();
		test_random_walks();
		drain_pending();
		repeat (20) @(posedge clk);
		$display("Covered %0d walk results: %0d found, %0d not present, %0d user-bit faults",
			n_found + n_absent + n_user_fault, n_found, n_absent, n_user_fault);
		$display("plus %0d table reads, %0d ignored items, %0d register writes, %0d stalls",
			n_reads, n_ignored, n_reg_writes, n_out_stalls);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
